/* sv/rtbf_pkg.sv */
package rtbf_pkg;

    localparam int VAL_W = 17;
    localparam logic [VAL_W-1:0] ONE_Q16 = 17'd65536;

    localparam int TRACK_LENGTH = 32;
    localparam int TOP_SPEED    = 3;
    localparam int AUDIO_START  = 5;

    // register indexes on the apb port
    localparam logic [1:0] REG_CHANGE = 2'd0;
    localparam logic [1:0] REG_TRAIN  = 2'd1;
    localparam logic [1:0] REG_WHEEL  = 2'd2;
    localparam logic [1:0] REG_AUDIO  = 2'd3;

    localparam logic [6:0]       RST_CHANGE = 7'd10;
    localparam logic [5:0]       RST_TRAIN  = 6'd8;
    localparam logic [VAL_W-1:0] RST_WHEEL  = 17'd45875;
    localparam logic [VAL_W-1:0] RST_AUDIO  = 17'd26214;
    localparam logic [6:0]       PCT_MAX    = 7'd100;

    // sensor pass / move selector
    localparam logic [1:0] SEL_WHEEL = 2'd0;
    localparam logic [1:0] SEL_AUDIO = 2'd1;
    localparam logic [1:0] SEL_MOVE  = 2'd2;

    // move contributions gathered into one destination cell
    localparam logic [1:0] TERM_STAY = 2'd0;
    localparam logic [1:0] TERM_UP   = 2'd1;
    localparam logic [1:0] TERM_DOWN = 2'd2;

    // floor(y/25) = (y*M)>>26, low by at most one for y < 2**21
    localparam logic [21:0] DIV25_M  = 22'd2684354;
    localparam int          DIV25_SH = 26;

    typedef struct packed {
        logic       cnt_clr;
        logic       cnt_step;
        logic       acc_clr;
        logic       sum_clr;
        logic       sum_acc;
        logic       init_wr;
        logic       capture;
        logic       sc_start;
        logic       sc_wr;
        logic       mv_rd;
        logic       mv_mul;
        logic       mv_div;
        logic       mv_acc;
        logic       mv_wr;
        logic       flip;
        logic       out_acc;
        logic [1:0] term;
        logic [1:0] sel;
    } rtbf_cmd_t;

    typedef struct packed {
        logic cell_last;
        logic k_last;
        logic p_last;
        logic div_busy;
        logic wheel;
        logic audio;
    } rtbf_sts_t;

endpackage

/* sv/rtbf_div.sv */
module rtbf_div import rtbf_pkg::*; #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg, rem_next, dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DVS_W:0]   shifted, diff;
    logic             ge;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= CW'(DVD_W);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/rtbf_ctrl.sv */
module rtbf_ctrl import rtbf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  rtbf_sts_t sts,
    output rtbf_cmd_t cmd
);

    localparam logic [4:0] ST_INIT     = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_PICK     = 5'd2;
    localparam logic [4:0] ST_SUM_RD   = 5'd3;
    localparam logic [4:0] ST_SUM_ACC  = 5'd4;
    localparam logic [4:0] ST_SC_RD    = 5'd5;
    localparam logic [4:0] ST_SC_START = 5'd6;
    localparam logic [4:0] ST_SC_WAIT  = 5'd7;
    localparam logic [4:0] ST_SC_WR    = 5'd8;
    localparam logic [4:0] ST_MV_RD    = 5'd9;
    localparam logic [4:0] ST_MV_MUL   = 5'd10;
    localparam logic [4:0] ST_MV_DIV   = 5'd11;
    localparam logic [4:0] ST_MV_ACC   = 5'd12;
    localparam logic [4:0] ST_MV_WR    = 5'd13;
    localparam logic [4:0] ST_OUT_RD   = 5'd14;
    localparam logic [4:0] ST_OUT_ACC  = 5'd15;
    localparam logic [4:0] ST_OUT_SEND = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] term_reg, term_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        term_next  = term_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr  = 1'b1;
                cmd.cnt_step = 1'b1;
                if (sts.cell_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    sel_next    = SEL_WHEEL;
                    state_next  = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.cnt_clr = 1'b1;
                cmd.sum_clr = 1'b1;
                cmd.acc_clr = 1'b1;
                term_next   = TERM_STAY;
                if (sel_reg == SEL_WHEEL) begin
                    if (sts.wheel) state_next = ST_SUM_RD;
                    else sel_next = SEL_AUDIO;
                end else if (sel_reg == SEL_AUDIO) begin
                    if (sts.audio) state_next = ST_SUM_RD;
                    else sel_next = SEL_MOVE;
                end else begin
                    state_next = ST_MV_RD;
                end
            end
            ST_SUM_RD: state_next = ST_SUM_ACC;
            ST_SUM_ACC: begin
                cmd.sum_acc = 1'b1;
                if (sts.cell_last) begin
                    cmd.cnt_clr = 1'b1;
                end else begin
                    cmd.cnt_step = 1'b1;
                end
                state_next = sts.cell_last ? ST_SC_RD : ST_SUM_RD;
            end
            ST_SC_RD: state_next = ST_SC_START;
            ST_SC_START: begin
                cmd.sc_start = 1'b1;
                state_next   = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                if (!sts.div_busy) state_next = ST_SC_WR;
            end
            ST_SC_WR: begin
                cmd.sc_wr = 1'b1;
                if (sts.cell_last) begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_PICK;
                end else begin
                    cmd.cnt_step = 1'b1;
                    state_next   = ST_SC_RD;
                end
            end
            ST_MV_RD: begin
                cmd.mv_rd  = 1'b1;
                state_next = ST_MV_MUL;
            end
            ST_MV_MUL: begin
                cmd.mv_mul = 1'b1;
                state_next = ST_MV_DIV;
            end
            ST_MV_DIV: begin
                cmd.mv_div = 1'b1;
                state_next = ST_MV_ACC;
            end
            ST_MV_ACC: begin
                cmd.mv_acc = 1'b1;
                if (term_reg == TERM_DOWN) begin
                    state_next = ST_MV_WR;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = ST_MV_RD;
                end
            end
            ST_MV_WR: begin
                cmd.mv_wr   = 1'b1;
                cmd.acc_clr = 1'b1;
                term_next   = TERM_STAY;
                if (sts.cell_last) begin
                    cmd.flip    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_OUT_RD;
                end else begin
                    cmd.cnt_step = 1'b1;
                    state_next   = ST_MV_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_ACC;
            ST_OUT_ACC: begin
                cmd.out_acc = 1'b1;
                if (sts.k_last) begin
                    state_next = ST_OUT_SEND;
                end else begin
                    cmd.cnt_step = 1'b1;
                    state_next   = ST_OUT_RD;
                end
            end
            ST_OUT_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.acc_clr = 1'b1;
                    if (sts.p_last) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.cnt_step = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.term = term_reg;
        cmd.sel  = sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sel_reg   <= SEL_WHEEL;
            term_reg  <= TERM_STAY;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            term_reg  <= term_next;
        end
    end

endmodule

/* sv/rtbf_dp.sv */
module rtbf_dp import rtbf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  rtbf_cmd_t        cmd,
    output rtbf_sts_t        sts,
    input  logic             wheel_fired,
    input  logic             audio_fired,
    input  logic [6:0]       change_percent,
    input  logic [5:0]       train_cells,
    input  logic [VAL_W-1:0] wheel_reliability,
    input  logic [VAL_W-1:0] audio_reliability,
    output logic [4:0]       position,
    output logic [VAL_W-1:0] probability,
    output logic             last
);

    localparam int SPEEDS = 2 * TOP_SPEED + 1;
    localparam int CELLS  = TRACK_LENGTH * SPEEDS;
    localparam int PW     = $clog2(TRACK_LENGTH);
    localparam int KW     = $clog2(SPEEDS);
    localparam int AW     = $clog2(CELLS);
    localparam int MW     = $clog2(2 * CELLS);
    localparam int SUM_W  = VAL_W + $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ACC_W  = VAL_W + $clog2(SPEEDS + 1);
    localparam int DVD_W  = 2 * VAL_W;
    localparam int SHARE  = 65536 / CELLS;
    localparam int AUD_OFS   = AUDIO_START % TRACK_LENGTH;
    localparam int MAX_OFS   = TOP_SPEED % TRACK_LENGTH;

    logic [VAL_W-1:0] mem [2*CELLS];
    logic [VAL_W-1:0] rd_data_reg;

    logic [PW-1:0] p_reg, base_reg, ps_reg;
    logic [KW-1:0] k_reg;
    logic          bank_reg;
    logic          wheel_reg, audio_reg;

    logic [SUM_W-1:0] sum0_reg, sum1_reg;
    logic [CNT_W-1:0] cnt0_reg, cnt1_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [24:0]      prod_reg;
    logic [20:0]      y_reg;
    logic [16:0]      q0_reg;

    logic          k_last, p_last;
    logic [AW-1:0] cell_addr, src_addr;
    logic [KW-1:0] src_k;
    logic [MW-1:0] rd_idx, wr_idx;
    logic          we;
    logic [VAL_W-1:0] wr_data;

    logic [6:0]       pc;
    logic [VAL_W-1:0] rel, tgt;
    logic [6:0]       first, span;
    logic [PW:0]      pos_ofs;
    logic [PW-1:0]    fofs;
    logic             covered, grp;
    logic [SUM_W-1:0] grp_sum;
    logic [CNT_W-1:0] grp_cnt;
    logic [DVD_W-1:0] dvd;
    logic [SUM_W-1:0] dvs;
    logic             div_busy;
    logic [DVD_W-1:0] quo;
    logic [VAL_W-1:0] quo_sat, acc_sat;
    logic [7:0]       wgt;
    logic [42:0]      recip;
    logic [21:0]      rem25;
    logic [16:0]      q_fix;

    assign k_last = k_reg == KW'(SPEEDS - 1);
    assign p_last = p_reg == PW'(TRACK_LENGTH - 1);

    always_comb begin
        pc  = (change_percent > PCT_MAX) ? PCT_MAX : change_percent;
        rel = (cmd.sel == SEL_WHEEL) ? wheel_reliability : audio_reliability;
        if (rel > ONE_Q16) rel = ONE_Q16;

        // coverage is a run of positions starting at first mod length
        first   = (cmd.sel == SEL_WHEEL) ? 7'd0 : 7'(AUDIO_START);
        fofs    = (cmd.sel == SEL_WHEEL) ? '0 : PW'(AUD_OFS);
        span    = ({1'b0, train_cells} > first) ? {1'b0, train_cells} - first : 7'd0;
        pos_ofs = (p_reg >= fofs) ? {1'b0, p_reg} - {1'b0, fofs}
                                  : {1'b0, p_reg} + (PW+1)'(TRACK_LENGTH) - {1'b0, fofs};
        covered = (span >= 7'(TRACK_LENGTH)) || ({{(7-PW-1){1'b0}}, pos_ofs} < span);
        grp     = covered && !((cmd.sel == SEL_WHEEL) && (k_reg == KW'(TOP_SPEED)));
        tgt     = grp ? rel : ONE_Q16 - rel;
        grp_sum = grp ? sum1_reg : sum0_reg;
        grp_cnt = grp ? cnt1_reg : cnt0_reg;

        if (grp_sum != '0) begin
            dvd = DVD_W'(rd_data_reg) * DVD_W'(tgt);
            dvs = grp_sum;
        end else begin
            dvd = DVD_W'(tgt);
            dvs = SUM_W'(grp_cnt);
        end
        quo_sat = (quo > DVD_W'(ONE_Q16)) ? ONE_Q16 : quo[VAL_W-1:0];
        acc_sat = (acc_reg > ACC_W'(ONE_Q16)) ? ONE_Q16 : acc_reg[VAL_W-1:0];

        cell_addr = AW'(AW'(p_reg) * AW'(SPEEDS) + AW'(k_reg));
        case (cmd.term)
            TERM_UP: begin
                src_k = (k_reg != '0) ? k_reg - 1'b1 : k_reg;
                wgt   = (k_reg == '0) ? 8'd0
                      : (k_reg == KW'(1)) ? {pc, 1'b0} : {1'b0, pc};
            end
            TERM_DOWN: begin
                src_k = k_last ? k_reg : k_reg + 1'b1;
                wgt   = k_last ? 8'd0
                      : (k_reg == KW'(SPEEDS - 2)) ? {pc, 1'b0} : {1'b0, pc};
            end
            default: begin
                src_k = k_reg;
                wgt   = 8'd200 - {pc, 1'b0};
            end
        endcase
        src_addr = AW'(AW'(ps_reg) * AW'(SPEEDS) + AW'(src_k));

        // quotient estimate taken from the product so that y and q0 load together
        recip = 43'(prod_reg[23:3]) * 43'(DIV25_M);
        rem25 = {1'b0, y_reg} - 22'(q0_reg) * 22'd25;
        q_fix = (rem25 >= 22'd25) ? q0_reg + 1'b1 : q0_reg;

        rd_idx = MW'(cmd.mv_rd ? src_addr : cell_addr) + (bank_reg ? MW'(CELLS) : MW'(0));
        we     = cmd.init_wr || cmd.sc_wr || cmd.mv_wr;
        if (cmd.mv_wr) begin
            wr_idx  = MW'(cell_addr) + (bank_reg ? MW'(0) : MW'(CELLS));
            wr_data = acc_sat;
        end else begin
            wr_idx  = MW'(cell_addr) + (bank_reg ? MW'(CELLS) : MW'(0));
            wr_data = cmd.init_wr ? VAL_W'(SHARE) : quo_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    rtbf_div #(.DVD_W(DVD_W), .DVS_W(SUM_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sc_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .quotient (quo)
    );

    // cell walk: ps tracks (p - speed) mod length for the move gather
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= '0;
            k_reg    <= '0;
            base_reg <= PW'(MAX_OFS);
            ps_reg   <= PW'(MAX_OFS);
            bank_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr) begin
                p_reg    <= '0;
                k_reg    <= '0;
                base_reg <= PW'(MAX_OFS);
                ps_reg   <= PW'(MAX_OFS);
            end else if (cmd.cnt_step) begin
                if (k_last) begin
                    k_reg    <= '0;
                    p_reg    <= p_last ? '0 : p_reg + 1'b1;
                    base_reg <= (base_reg == PW'(TRACK_LENGTH - 1)) ? '0 : base_reg + 1'b1;
                    ps_reg   <= (base_reg == PW'(TRACK_LENGTH - 1)) ? '0 : base_reg + 1'b1;
                end else begin
                    k_reg  <= k_reg + 1'b1;
                    ps_reg <= (ps_reg == '0) ? PW'(TRACK_LENGTH - 1) : ps_reg - 1'b1;
                end
            end
            if (cmd.flip) begin
                bank_reg <= !bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            wheel_reg <= wheel_fired;
            audio_reg <= audio_fired;
        end
        if (cmd.sum_clr) begin
            sum0_reg <= '0;
            sum1_reg <= '0;
            cnt0_reg <= '0;
            cnt1_reg <= '0;
        end else if (cmd.sum_acc) begin
            if (grp) begin
                sum1_reg <= sum1_reg + SUM_W'(rd_data_reg);
                cnt1_reg <= cnt1_reg + 1'b1;
            end else begin
                sum0_reg <= sum0_reg + SUM_W'(rd_data_reg);
                cnt0_reg <= cnt0_reg + 1'b1;
            end
        end
        if (cmd.mv_mul) begin
            prod_reg <= 25'(rd_data_reg) * 25'(wgt);
        end
        if (cmd.mv_div) begin
            y_reg  <= prod_reg[23:3];
            q0_reg <= recip[DIV25_SH+16:DIV25_SH];
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.mv_acc) begin
            acc_reg <= acc_reg + ACC_W'(q_fix);
        end else if (cmd.out_acc) begin
            acc_reg <= acc_reg + ACC_W'(rd_data_reg);
        end
    end

    always_comb begin
        sts.cell_last = k_last && p_last;
        sts.k_last    = k_last;
        sts.p_last    = p_last;
        sts.div_busy  = div_busy;
        sts.wheel     = wheel_reg;
        sts.audio     = audio_reg;
    end

    assign position    = 5'(p_reg);
    assign probability = acc_sat;
    assign last        = p_last;

endmodule

/* sv/ring_track_bayes_position_filter.sv */
// per tick, with C = TRACK_LENGTH*(2*TOP_SPEED+1) cells: each fired sensor is applied first (the
// cells are summed, then each cell is rescaled by one 34-step division), then the move is
// gathered cell by cell, then each result word is summed over speeds and sent, waiting on output
// stalls; one tick is worked at a time, and a new tick is taken only once the last word is sent
// after reset the belief ram is filled with the uniform share, one cell a cycle over all C cells,
// before the first word is taken; registers reset to 10, 8, 45875, 26214
module ring_track_bayes_position_filter import rtbf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_wheel_fired,
    input  logic        s_audio_fired,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_position,
    output logic [16:0] m_probability,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]       change_reg;
    logic [5:0]       train_reg;
    logic [VAL_W-1:0] wheel_rel_reg, audio_rel_reg;
    rtbf_cmd_t        cmd;
    rtbf_sts_t        sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            change_reg    <= RST_CHANGE;
            train_reg     <= RST_TRAIN;
            wheel_rel_reg <= RST_WHEEL;
            audio_rel_reg <= RST_AUDIO;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_CHANGE: change_reg    <= pwdata[6:0];
                REG_TRAIN:  train_reg     <= pwdata[5:0];
                REG_WHEEL:  wheel_rel_reg <= pwdata[VAL_W-1:0];
                REG_AUDIO:  audio_rel_reg <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANGE: prdata = {25'd0, change_reg};
            REG_TRAIN:  prdata = {26'd0, train_reg};
            REG_WHEEL:  prdata = {15'd0, wheel_rel_reg};
            REG_AUDIO:  prdata = {15'd0, audio_rel_reg};
            default:    prdata = '0;
        endcase
    end

    rtbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rtbf_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .wheel_fired       (s_wheel_fired),
        .audio_fired       (s_audio_fired),
        .change_percent    (change_reg),
        .train_cells       (train_reg),
        .wheel_reliability (wheel_rel_reg),
        .audio_reliability (audio_rel_reg),
        .position          (m_position),
        .probability       (m_probability),
        .last              (m_last)
    );

endmodule
